>>> design/spnc_pkg.sv
package spnc_pkg;

   localparam int IDX_W      = 8;
   localparam int COLOR_W    = 8;
   localparam int RGB_W      = 3 * COLOR_W;
   localparam int SQ_W       = 2 * COLOR_W;
   localparam int DIST_W     = 18;
   localparam int SPLIT_W    = 9;
   localparam int DARKEN_W   = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam logic [SPLIT_W-1:0]  SPLIT_RESET  = 9'd208;
   localparam logic [DARKEN_W-1:0] DARKEN_RESET = 3'd3;
   localparam logic [DARKEN_W-1:0] DARKEN_MAX   = 3'd4;
   localparam logic [DIST_W-1:0]   DIST_LIMIT   = 18'd195075;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPLIT  = 1'b0,
      CSR_DARKEN = 1'b1
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SRC  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   function automatic logic [COLOR_W-1:0] darken(input logic [COLOR_W-1:0] c,
                                                 input logic [DARKEN_W-1:0] num);
      logic [COLOR_W+DARKEN_W-1:0] prod;
      prod = (COLOR_W+DARKEN_W)'(c) * (COLOR_W+DARKEN_W)'(num);
      return prod[COLOR_W+1:2];
   endfunction

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                               input logic [COLOR_W-1:0] b);
      logic [COLOR_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

>>> design/shadow_palette_nearest_color.sv
// Shadow palette nearest color search.
//
// The req channel carries one word per command. A write word stores red,
// green and blue into the palette entry named by entry_index and gives no
// rsp word. A query word darkens the source entry by darken_numerator/4 and
// searches the entries on the source's side of split_color for the least
// squared RGB distance; it gives one rsp word with nearest_color and
// min_distance. The csr channel writes split_color (index 0) and
// darken_numerator (index 1) and is always ready.
// A query reads its source entry and then the palette entries in order through
// the single read port of the palette memory, which returns one entry per cycle.
// The block works on one word at a time; req_ready is high while it is idle,
// so no new word is taken while a query is still in progress.
// A finished result waits in the output register while the receiver stalls,
// and a new req word is accepted meanwhile; a later query holds its result
// until the register is free.
// Reset clears the per-entry valid flags, so every entry reads as black
// at once, and restores split_color to 208 and darken_numerator to 3.
module shadow_palette_nearest_color #(
   parameter int PALETTE_ENTRIES = spnc_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [spnc_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [spnc_pkg::COLOR_W-1:0]      req_red,
   input  logic [spnc_pkg::COLOR_W-1:0]      req_green,
   input  logic [spnc_pkg::COLOR_W-1:0]      req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spnc_pkg::IDX_W-1:0]        rsp_nearest_color,
   output logic [spnc_pkg::DIST_W-1:0]       rsp_min_distance,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spnc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spnc_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] CNT_END = CW'(PALETTE_ENTRIES);
   localparam logic [spnc_pkg::SPLIT_W-1:0] ENTRIES_W = spnc_pkg::SPLIT_W'(PALETTE_ENTRIES);

   spnc_pkg::state_type state_ff, state_in;

   logic [spnc_pkg::RGB_W-1:0] palette_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] entry_vld_ff;
   logic [spnc_pkg::RGB_W-1:0] rd_data_ff;
   logic                       rd_ok_ff;
   logic [AW-1:0]              rd_addr;
   logic [spnc_pkg::RGB_W-1:0] rd_color;

   logic [spnc_pkg::SPLIT_W-1:0]  split_ff;
   logic [spnc_pkg::DARKEN_W-1:0] darken_ff;

   logic                         req_fire;
   logic                         mem_we;
   logic                         issue;
   logic [CW-1:0]                cnt_ff;
   logic [spnc_pkg::IDX_W-1:0]   src_idx_ff;
   logic                         src_black_ff;
   logic                         src_upper_ff;
   logic [spnc_pkg::COLOR_W-1:0] tr_ff, tg_ff, tb_ff;
   logic [spnc_pkg::DARKEN_W-1:0] num_sat;

   logic                         s1_vld_ff;
   logic [AW-1:0]                s1_idx_ff;
   logic                         s1_group;
   logic                         s2_vld_ff;
   logic [AW-1:0]                s2_idx_ff;
   logic [spnc_pkg::DIST_W-1:0]  dist_ff;
   logic [spnc_pkg::DIST_W-1:0]  dist_in;

   logic                         found_ff;
   logic [AW-1:0]                best_idx_ff;
   logic [spnc_pkg::DIST_W-1:0]  best_dist_ff;
   logic                         better;

   logic                         rsp_load;
   logic                         rsp_valid_ff;
   logic [spnc_pkg::IDX_W-1:0]   rsp_color_ff;
   logic [spnc_pkg::DIST_W-1:0]  rsp_dist_ff;

   assign req_ready = (state_ff == spnc_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign mem_we    = req_fire && (req_command == spnc_pkg::CMD_WRITE) &&
                      ({1'b0, req_entry_index} < ENTRIES_W);
   assign csr_ready = 1'b1;

   assign issue   = ((state_ff == spnc_pkg::ST_SRC) || (state_ff == spnc_pkg::ST_SCAN)) &&
                    (cnt_ff != CNT_END);
   assign rd_addr = (state_ff == spnc_pkg::ST_IDLE) ? req_entry_index[AW-1:0] : cnt_ff[AW-1:0];
   assign rd_color = rd_ok_ff ? rd_data_ff : '0;

   assign num_sat = (darken_ff > spnc_pkg::DARKEN_MAX) ? spnc_pkg::DARKEN_MAX : darken_ff;

   assign s1_group = ((spnc_pkg::SPLIT_W'(s1_idx_ff) >= split_ff) == src_upper_ff);
   assign dist_in  = spnc_pkg::DIST_W'(spnc_pkg::sq_diff(tr_ff, rd_color[23:16])) +
                     spnc_pkg::DIST_W'(spnc_pkg::sq_diff(tg_ff, rd_color[15:8])) +
                     spnc_pkg::DIST_W'(spnc_pkg::sq_diff(tb_ff, rd_color[7:0]));

   assign better   = s2_vld_ff && (!found_ff || (dist_ff < best_dist_ff));
   assign rsp_load = (state_ff == spnc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spnc_pkg::ST_IDLE: begin
            if (req_fire && (req_command == spnc_pkg::CMD_QUERY)) begin
               state_in = spnc_pkg::ST_SRC;
            end
         end
         spnc_pkg::ST_SRC: begin
            state_in = spnc_pkg::ST_SCAN;
         end
         spnc_pkg::ST_SCAN: begin
            if ((cnt_ff == CNT_END) && !s1_vld_ff && !s2_vld_ff) begin
               state_in = spnc_pkg::ST_DONE;
            end
         end
         spnc_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = spnc_pkg::ST_IDLE;
            end
         end
         default: state_in = spnc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[req_entry_index[AW-1:0]] <= {req_red, req_green, req_blue};
      end
      rd_data_ff <= palette_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spnc_pkg::ST_IDLE;
         entry_vld_ff <= '0;
         rd_ok_ff     <= 1'b0;
         split_ff     <= spnc_pkg::SPLIT_RESET;
         darken_ff    <= spnc_pkg::DARKEN_RESET;
         cnt_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_ok_ff <= entry_vld_ff[rd_addr];
         if (mem_we) begin
            entry_vld_ff[req_entry_index[AW-1:0]] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               spnc_pkg::CSR_SPLIT:  split_ff  <= csr_data;
               spnc_pkg::CSR_DARKEN: darken_ff <= csr_data[spnc_pkg::DARKEN_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            cnt_ff   <= '0;
            found_ff <= 1'b0;
         end else begin
            if (issue) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
            if (better) begin
               found_ff <= 1'b1;
            end
         end
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff && s1_group;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         src_idx_ff   <= req_entry_index;
         src_black_ff <= ({1'b0, req_entry_index} >= ENTRIES_W);
         src_upper_ff <= ({1'b0, req_entry_index} >= split_ff);
      end
      if (state_ff == spnc_pkg::ST_SRC) begin
         tr_ff <= src_black_ff ? '0 : spnc_pkg::darken(rd_color[23:16], num_sat);
         tg_ff <= src_black_ff ? '0 : spnc_pkg::darken(rd_color[15:8], num_sat);
         tb_ff <= src_black_ff ? '0 : spnc_pkg::darken(rd_color[7:0], num_sat);
      end
      s1_idx_ff <= cnt_ff[AW-1:0];
      s2_idx_ff <= s1_idx_ff;
      dist_ff   <= dist_in;
      if (better) begin
         best_idx_ff  <= s2_idx_ff;
         best_dist_ff <= dist_ff;
      end
      if (rsp_load) begin
         rsp_color_ff <= found_ff ? spnc_pkg::IDX_W'(best_idx_ff) : src_idx_ff;
         rsp_dist_ff  <= found_ff ? best_dist_ff : '1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_color = rsp_color_ff;
   assign rsp_min_distance  = rsp_dist_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("search state is not one-hot");

   a_scan_only: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff) |-> (state_ff == spnc_pkg::ST_SCAN))
      else $error("scan pipeline busy outside the scan state");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_END)
      else $error("scan counter ran past the palette");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_dist_ff <= spnc_pkg::DIST_LIMIT))
      else $error("best distance exceeds the largest RGB distance");

   a_done_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == spnc_pkg::ST_IDLE))
      else $error("result load did not present a word and return to idle");

endmodule
